[rtl/core/hrt_pkg.sv]
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types and constants of the handshake retry transmit sequencer.
// ----------------------------------------------------------------------------
package hrt_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int SEQ_W     = 7;
    localparam int TIME_W    = 16;
    localparam int ATT_W     = 4;
    localparam int CFG_W     = 16;
    localparam int CNT_W     = 2;
    localparam int MAX_RES   = 3;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [ATT_W-1:0]  RETRY_RST   = 4'd3;
    localparam logic [SEQ_W-1:0]  SEQ_RST     = 7'd0;
    localparam logic [TIME_W-1:0] TIME_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_NEW      = 2'd0,
        OP_HS_ACK   = 2'd1,
        OP_DATA_ACK = 2'd2,
        OP_TICK     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_HS   = 3'd0,
        KIND_DATA = 3'd1,
        KIND_DONE = 3'd2,
        KIND_FAIL = 3'd3,
        KIND_BUSY = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_HS   = 2'd1,
        PH_WAIT_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_RETRY   = 2'd1,
        CFG_SEQ     = 2'd2
    } t_cfg_idx;

    // all results of one item share the sequence number
    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        t_kind [MAX_RES-1:0]  kinds;
        logic [SEQ_W-1:0]     seq;
        logic [PAYLOAD_W-1:0] payload;
    } t_bundle;

endpackage

[rtl/core/hrt_in_if.sv]
// ----------------------------------------------------------------------------
// hrt_in_if
// Input item channel: valid/ready handshake with opcode and payload.
// ----------------------------------------------------------------------------
interface hrt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] payload;

    modport source (output valid, output opcode, output payload, input ready);
    modport sink   (input valid, input opcode, input payload, output ready);
endinterface

[rtl/core/hrt_out_if.sv]
// ----------------------------------------------------------------------------
// hrt_out_if
// Result channel: valid/ready handshake carrying one send command.
// ----------------------------------------------------------------------------
interface hrt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [6:0]  seq_out;
    logic [31:0] payload_out;
    logic        last;

    modport source (output valid, output kind, output seq_out, output payload_out,
                    output last, input ready);
    modport sink   (input valid, input kind, input seq_out, input payload_out,
                    input last, output ready);
endinterface

[rtl/core/hrt_front.sv]
// ----------------------------------------------------------------------------
// hrt_front
// Accepts items, runs the transaction state machine and builds the bundle of
// results each item causes. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module hrt_front #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_opcode,
    input  logic [31:0]             i_payload,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_q_full,
    output logic                    o_push,
    output hrt_pkg::t_bundle        o_bundle
);
    import hrt_pkg::*;

    localparam int HELD_W = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;

    t_phase              r_phase, n_phase;
    logic [ATT_W-1:0]    r_att, n_att;
    logic [TIME_W-1:0]   r_el, n_el;
    logic [SEQ_W-1:0]    r_seq, n_seq;
    logic                r_hs_seen, n_hs_seen;
    logic                r_data_seen, n_data_seen;
    logic [HELD_W-1:0]   r_held, n_held;
    logic [TIME_W-1:0]   r_timeout;
    logic [ATT_W-1:0]    r_retry;

    logic                accept;
    logic [TIME_W-1:0]   el_inc;
    logic                go_hs, go_data, go_fin;
    t_kind               fin_kind;
    logic [CNT_W-1:0]    cnt;
    t_kind [MAX_RES-1:0] kinds;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign el_inc  = (r_el == TIME_MAX) ? r_el : r_el + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_att       = r_att;
        n_el        = r_el;
        n_seq       = r_seq;
        n_hs_seen   = r_hs_seen;
        n_data_seen = r_data_seen;
        n_held      = r_held;
        go_hs       = 1'b0;
        go_data     = 1'b0;
        go_fin      = 1'b0;
        fin_kind    = KIND_DONE;
        cnt         = '0;
        kinds       = '{default: KIND_HS};

        case (t_op'(i_opcode))
            OP_NEW: begin
                if (r_phase == PH_IDLE) begin
                    n_held = i_payload[HELD_W-1:0];
                    n_att  = '0;
                    go_hs  = 1'b1;
                end else begin
                    kinds[cnt] = KIND_BUSY;
                    cnt        = cnt + 1'b1;
                end
            end
            OP_HS_ACK: begin
                n_hs_seen = 1'b1;
                if (r_phase == PH_WAIT_HS) begin
                    n_hs_seen = 1'b0;
                    n_att     = '0;
                    go_data   = 1'b1;
                end
            end
            OP_DATA_ACK: begin
                n_data_seen = 1'b1;
                if (r_phase == PH_WAIT_DATA) begin
                    n_data_seen = 1'b0;
                    go_fin      = 1'b1;
                end
            end
            OP_TICK: begin
                if (r_phase == PH_WAIT_HS || r_phase == PH_WAIT_DATA) begin
                    n_el = el_inc;
                    if (el_inc >= r_timeout) begin
                        if (r_att < r_retry) begin
                            if (r_phase == PH_WAIT_HS) go_hs = 1'b1;
                            else                       go_data = 1'b1;
                        end else begin
                            go_fin   = 1'b1;
                            fin_kind = KIND_FAIL;
                        end
                    end
                end
            end
            default: ;
        endcase

        // chained results: a latched ack is consumed on entry to its wait
        if (go_hs) begin
            kinds[cnt] = KIND_HS;
            cnt        = cnt + 1'b1;
            n_att      = n_att + 1'b1;
            n_el       = '0;
            n_phase    = PH_WAIT_HS;
            if (n_hs_seen) begin
                n_hs_seen = 1'b0;
                n_att     = '0;
                go_data   = 1'b1;
            end
        end
        if (go_data) begin
            kinds[cnt] = KIND_DATA;
            cnt        = cnt + 1'b1;
            n_att      = n_att + 1'b1;
            n_el       = '0;
            n_phase    = PH_WAIT_DATA;
            if (n_data_seen) begin
                n_data_seen = 1'b0;
                go_fin      = 1'b1;
            end
        end
        if (go_fin) begin
            kinds[cnt] = fin_kind;
            cnt        = cnt + 1'b1;
            n_phase    = PH_IDLE;
            n_att      = '0;
            n_el       = '0;
            n_seq      = r_seq + 1'b1;
        end
    end

    assign o_push           = accept && (cnt != '0);
    assign o_bundle.cnt     = cnt;
    assign o_bundle.kinds   = kinds;
    assign o_bundle.seq     = r_seq;
    assign o_bundle.payload = PAYLOAD_W'(n_held);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_att       <= '0;
            r_el        <= '0;
            r_seq       <= SEQ_RST;
            r_hs_seen   <= 1'b0;
            r_data_seen <= 1'b0;
            r_timeout   <= TIMEOUT_RST;
            r_retry     <= RETRY_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMEOUT: r_timeout <= i_cfg_data[TIME_W-1:0];
                CFG_RETRY:   r_retry   <= i_cfg_data[ATT_W-1:0];
                CFG_SEQ:     r_seq     <= i_cfg_data[SEQ_W-1:0];
                default: ;
            endcase
        end else if (accept) begin
            r_phase     <= n_phase;
            r_att       <= n_att;
            r_el        <= n_el;
            r_seq       <= n_seq;
            r_hs_seen   <= n_hs_seen;
            r_data_seen <= n_data_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

[rtl/core/hrt_queue.sv]
// ----------------------------------------------------------------------------
// hrt_queue
// Two-entry queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module hrt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hrt_pkg::t_bundle i_bundle,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output hrt_pkg::t_bundle o_bundle
);
    import hrt_pkg::*;

    t_bundle    r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_bundle = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

endmodule

[rtl/core/hrt_back.sv]
// ----------------------------------------------------------------------------
// hrt_back
// Walks the head bundle; presents one result per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module hrt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hrt_pkg::t_bundle i_bundle,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_kind,
    output logic [6:0]       o_seq,
    output logic [31:0]      o_payload,
    output logic             o_last
);
    import hrt_pkg::*;

    logic [CNT_W-1:0] r_idx;
    t_kind            kind;
    logic             fire;

    assign kind      = i_bundle.kinds[r_idx];
    assign o_valid   = i_valid;
    assign o_kind    = kind;
    assign o_seq     = i_bundle.seq;
    assign o_payload = (kind == KIND_DATA) ? i_bundle.payload : '0;
    assign o_last    = (r_idx == i_bundle.cnt - 1'b1);
    assign fire      = o_valid && i_ready;
    assign o_pop     = fire && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= o_last ? '0 : r_idx + 1'b1;
        end
    end

endmodule

[rtl/core/handshake_retry_transmit_fsm.sv]
// ----------------------------------------------------------------------------
// handshake_retry_transmit_fsm
// Stop-and-wait transmit sequencer with handshake, timeout and retries.
//
// i_item carries events: new payload, handshake ack, data ack, ms tick.
// o_result carries send commands: send handshake, send data, done, failed,
// busy reject, with the sequence number and, for send data, the payload.
// last marks the final result caused by one item; an item may cause none
// (a tick or an ack that only updates state) or up to three results.
// An item's bundle of results is registered in the queue on acceptance and
// its first result shows on o_result from there. Sustained rate is one item
// per cycle while each item causes at most one result and o_result is ready;
// the results of one item take the result port one after another.
// A two-entry bundle queue sits between the event front end and the result
// back end, so items keep flowing while a result waits on a stalled o_result;
// i_item.ready drops only when the queue is full.
// Reset returns to idle, clears attempts, elapsed time and latched acks,
// and loads the default timeout, retry limit and sequence number.
// Configuration must be written on i_cfg_we only while idle; not enforced.
// ----------------------------------------------------------------------------
module handshake_retry_transmit_fsm #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrt_in_if.sink      i_item,
    hrt_out_if.source   o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import hrt_pkg::*;

    logic    q_full, q_valid, push, pop;
    t_bundle f_bundle, q_bundle;

    hrt_front #(
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_item.valid),
        .o_ready    (i_item.ready),
        .i_opcode   (i_item.opcode),
        .i_payload  (i_item.payload),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_bundle   (f_bundle)
    );

    hrt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (f_bundle),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .i_pop    (pop),
        .o_bundle (q_bundle)
    );

    hrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_bundle  (q_bundle),
        .o_pop     (pop),
        .o_valid   (o_result.valid),
        .i_ready   (o_result.ready),
        .o_kind    (o_result.kind),
        .o_seq     (o_result.seq_out),
        .o_payload (o_result.payload_out),
        .o_last    (o_result.last)
    );

endmodule

[rtl/core/hrt_checker.sv]
// ----------------------------------------------------------------------------
// hrt_checker
// Port-level checks on the result channel of the transmit sequencer.
// ----------------------------------------------------------------------------
module hrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_kind,
    input logic [31:0] i_out_payload,
    input logic        i_out_last
);
    import hrt_pkg::*;

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_last))
        else $error("stalled result changed");

    // done, failed and busy reject always end an item's results
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_DONE || i_out_kind == KIND_FAIL
            || i_out_kind == KIND_BUSY) |-> i_out_last)
        else $error("terminal result without last");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_DATA |-> i_out_payload == '0)
        else $error("payload on non-data result");

endmodule

bind handshake_retry_transmit_fsm hrt_checker u_hrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_kind    (o_result.kind),
    .i_out_payload (o_result.payload_out),
    .i_out_last    (o_result.last)
);
